// ----- rtl/cpr_pkg.sv -----
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and fixed-point constants shared by the contact pair resolver.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] SLEEP_Q2   = ((64'd1 << (2 * FRAC_BITS)) + 64'd50) / 64'd100;
    localparam logic [63:0] SLOP_Q     = (64'd5 * ONE_Q + 64'd50) / 64'd100;
    localparam logic [63:0] FULL_PEN_Q = 64'd5 * ONE_Q;
    localparam logic [63:0] FRIC_EPS_Q = (ONE_Q + 64'd500) / 64'd1000;

    localparam int          DIV5_SH = FRAC_BITS + 8;
    localparam logic [63:0] DIV5_K  = ((64'd1 << DIV5_SH) + 64'd4) / 64'd5;
    localparam int          SCW     = FRAC_BITS + 5;
    localparam int          K5W     = FRAC_BITS + 6;

    localparam int          DIV10_SH = 24;
    localparam logic [20:0] DIV10_K  = 21'd1677722;

    typedef logic signed [31:0] q_t;

    function automatic q_t sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input q_t v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

// ----- rtl/contact_pair_resolve_top.sv -----
// ----------------------------------------------------------------------------
// contact_pair_resolve_top
// Resolves one colliding box pair per transaction in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | contact normal, depth, offset, velocities
//  m_      | out       | m_valid / m_ready | moves, new velocities, flags
//  cfg     | in        | cfg_we            | ground friction
// Each transaction passes four register stages, the last of which drives m_valid,
// and one transaction enters every cycle unless a stall on m_ready holds the stages.
// The stage depth is set by the squared-speed and friction multipliers.
// A stall on m_ready holds every stage; reset clears only the valid bits and gf_reg.
module contact_pair_resolve_top
    import cpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_normal_code,
    input  logic [30:0] s_penetration,
    input  q_t          s_center_dx,
    input  q_t          s_center_dy,
    input  q_t          s_vel_a_x,
    input  q_t          s_vel_a_y,
    input  q_t          s_vel_b_x,
    input  q_t          s_vel_b_y,
    input  logic        s_a_dynamic,
    input  logic        s_b_dynamic,
    input  logic        s_a_has_body,
    input  logic        s_b_has_body,
    output logic        m_valid,
    input  logic        m_ready,
    output q_t          m_a_move_x,
    output q_t          m_a_move_y,
    output q_t          m_b_move_x,
    output q_t          m_b_move_y,
    output q_t          m_new_vel_a_x,
    output q_t          m_new_vel_a_y,
    output q_t          m_new_vel_b_x,
    output q_t          m_new_vel_b_y,
    output logic        m_a_grounded,
    output logic        m_b_grounded,
    output logic        m_a_moved,
    output logic        m_b_moved
);

    logic [19:0] gf_reg;
    logic        adv;

    // Stage 1
    logic               v1_reg, axis1_reg, neg1_reg, dyn_a1_reg, dyn_b1_reg;
    logic               body_a1_reg, body_b1_reg, full1_reg;
    logic [63:0]        sq_ax1_reg, sq_ay1_reg, sq_bx1_reg, sq_by1_reg;
    logic [30:0]        corr_sl1_reg;
    logic [SCW+K5W-1:0] c45_1_reg;
    logic signed [33:0] vn1_reg, vt1_reg;
    q_t                 va_n1_reg, va_t1_reg, vb_n1_reg, vb_t1_reg;
    logic [40:0]        mu_raw1_reg;

    // Stage 2
    logic               v2_reg, axis2_reg, both2_reg, tneg2_reg, vt_pos2_reg, fric2_reg;
    logic               fa2_reg, fb2_reg, gr_a2_reg, gr_b2_reg, mv_a2_reg, mv_b2_reg;
    logic [33:0]        magvt2_reg;
    logic [16:0]        mu2_reg;
    q_t                 mova2_reg, movb2_reg;
    q_t                 va_n2_reg, va_t2_reg, vb_n2_reg, vb_t2_reg;

    // Stage 3
    logic               v3_reg, axis3_reg, both3_reg, tneg3_reg, vt_pos3_reg, fric3_reg;
    logic               fa3_reg, fb3_reg, gr_a3_reg, gr_b3_reg, mv_a3_reg, mv_b3_reg;
    logic [50:0]        prod3_reg;
    q_t                 mova3_reg, movb3_reg;
    q_t                 va_n3_reg, va_t3_reg, vb_n3_reg, vb_t3_reg;

    // Stage 4
    logic               v4_reg, axis4_reg, gr_a4_reg, gr_b4_reg, mv_a4_reg, mv_b4_reg;
    q_t                 mova4_reg, movb4_reg;
    q_t                 va_n4_reg, va_t4_reg, vb_n4_reg, vb_t4_reg;

    assign adv     = !v4_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gf_reg <= '0;
        end else if (cfg_we) begin
            gf_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: orientation, squared speeds, raw correction, relative velocity, raw friction.
    logic               axis0, flip0, neg0, tneg0;
    q_t                 off0, an0, at0, bn0, bt0;
    logic [31:0]        max0, may0, mbx0, mby0;
    logic [30:0]        corr_sl0;
    logic [SCW-1:0]     c4_0;
    logic signed [32:0] reln0, relt0;

    always_comb begin
        axis0    = s_normal_code[1];
        off0     = axis0 ? s_center_dy : s_center_dx;
        flip0    = s_normal_code[0] ? (off0 > 0) : off0[31];
        neg0     = s_normal_code[0] ^ flip0;
        tneg0    = axis0 ? !neg0 : neg0;
        an0      = axis0 ? s_vel_a_y : s_vel_a_x;
        at0      = axis0 ? s_vel_a_x : s_vel_a_y;
        bn0      = axis0 ? s_vel_b_y : s_vel_b_x;
        bt0      = axis0 ? s_vel_b_x : s_vel_b_y;
        max0     = mag32(s_vel_a_x);
        may0     = mag32(s_vel_a_y);
        mbx0     = mag32(s_vel_b_x);
        mby0     = mag32(s_vel_b_y);
        corr_sl0 = (64'(s_penetration) > SLOP_Q) ? (s_penetration - SLOP_Q[30:0]) : '0;
        c4_0     = {corr_sl0[SCW-3:0], 2'b00};
        reln0    = (s_a_has_body ? 33'(an0) : 33'sd0) - (s_b_has_body ? 33'(bn0) : 33'sd0);
        relt0    = (s_a_has_body ? 33'(at0) : 33'sd0) - (s_b_has_body ? 33'(bt0) : 33'sd0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            axis1_reg    <= axis0;
            neg1_reg     <= neg0;
            dyn_a1_reg   <= s_a_dynamic;
            dyn_b1_reg   <= s_b_dynamic;
            body_a1_reg  <= s_a_has_body;
            body_b1_reg  <= s_b_has_body;
            full1_reg    <= 64'(s_penetration) <= FULL_PEN_Q;
            sq_ax1_reg   <= 64'(max0) * 64'(max0);
            sq_ay1_reg   <= 64'(may0) * 64'(may0);
            sq_bx1_reg   <= 64'(mbx0) * 64'(mbx0);
            sq_by1_reg   <= 64'(mby0) * 64'(mby0);
            corr_sl1_reg <= corr_sl0;
            c45_1_reg    <= (SCW+K5W)'(c4_0) * (SCW+K5W)'(DIV5_K[K5W-1:0]);
            vn1_reg      <= neg0 ? -34'(reln0) : 34'(reln0);
            vt1_reg      <= tneg0 ? -34'(relt0) : 34'(relt0);
            va_n1_reg    <= an0;
            va_t1_reg    <= at0;
            vb_n1_reg    <= bn0;
            vb_t1_reg    <= bt0;
            mu_raw1_reg  <= 41'(gf_reg) * 41'(DIV10_K);
        end
    end

    // Stage 2: anchors, position split, normal impulse, friction setup.
    logic               still_a, still_b, both, active, anyb, ua, ub;
    logic [30:0]        corr, share;
    logic [34:0]        jmag;
    logic signed [35:0] jsgn;
    logic [16:0]        mu_d;
    logic [33:0]        magvt;

    always_comb begin
        both    = dyn_a1_reg && dyn_b1_reg;
        still_a = body_a1_reg && ({1'b0, sq_ax1_reg} + {1'b0, sq_ay1_reg} < 65'(SLEEP_Q2));
        still_b = body_b1_reg && ({1'b0, sq_bx1_reg} + {1'b0, sq_by1_reg} < 65'(SLEEP_Q2));
        corr    = full1_reg ? 31'(c45_1_reg >> DIV5_SH) : corr_sl1_reg;
        active  = (dyn_a1_reg || dyn_b1_reg) && (corr != '0);
        anyb    = active && (body_a1_reg || body_b1_reg);
        share   = both ? (corr >> 1) : corr;
        jmag    = 35'(-35'(vn1_reg));
        if (both) begin
            jmag = jmag >> 1;
        end
        jsgn    = neg1_reg ? -36'({1'b0, jmag}) : 36'({1'b0, jmag});
        ua      = anyb && vn1_reg[33] && body_a1_reg && dyn_a1_reg;
        ub      = anyb && vn1_reg[33] && body_b1_reg && dyn_b1_reg;
        mu_d    = 17'(mu_raw1_reg >> DIV10_SH);
        if (64'(mu_d) > ONE_Q) begin
            mu_d = 17'(ONE_Q);
        end
        magvt   = vt1_reg[33] ? 34'(-vt1_reg) : 34'(vt1_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            axis2_reg   <= axis1_reg;
            both2_reg   <= both;
            tneg2_reg   <= axis1_reg ? !neg1_reg : neg1_reg;
            vt_pos2_reg <= vt1_reg > 0;
            fric2_reg   <= anyb && (64'(magvt) > FRIC_EPS_Q);
            fa2_reg     <= body_a1_reg && dyn_a1_reg;
            fb2_reg     <= body_b1_reg && dyn_b1_reg;
            gr_a2_reg   <= anyb && axis1_reg && neg1_reg && body_a1_reg;
            gr_b2_reg   <= anyb && axis1_reg && !neg1_reg && body_b1_reg;
            mv_a2_reg   <= active && dyn_a1_reg && !still_a;
            mv_b2_reg   <= active && dyn_b1_reg && !still_b;
            mova2_reg   <= (active && dyn_a1_reg && !still_a) ?
                           (neg1_reg ? -32'(share) : 32'(share)) : '0;
            movb2_reg   <= (active && dyn_b1_reg && !still_b) ?
                           (neg1_reg ? 32'(share) : -32'(share)) : '0;
            magvt2_reg  <= magvt;
            mu2_reg     <= mu_d;
            va_n2_reg   <= ua ? sat32(40'(va_n1_reg) + 40'(jsgn)) : va_n1_reg;
            vb_n2_reg   <= ub ? sat32(40'(vb_n1_reg) - 40'(jsgn)) : vb_n1_reg;
            va_t2_reg   <= va_t1_reg;
            vb_t2_reg   <= vb_t1_reg;
        end
    end

    // Stage 3: friction magnitude product.
    always_ff @(posedge aclk) begin
        if (adv) begin
            axis3_reg   <= axis2_reg;
            both3_reg   <= both2_reg;
            tneg3_reg   <= tneg2_reg;
            vt_pos3_reg <= vt_pos2_reg;
            fric3_reg   <= fric2_reg;
            fa3_reg     <= fa2_reg;
            fb3_reg     <= fb2_reg;
            gr_a3_reg   <= gr_a2_reg;
            gr_b3_reg   <= gr_b2_reg;
            mv_a3_reg   <= mv_a2_reg;
            mv_b3_reg   <= mv_b2_reg;
            mova3_reg   <= mova2_reg;
            movb3_reg   <= movb2_reg;
            prod3_reg   <= 51'(magvt2_reg) * 51'(mu2_reg);
            va_n3_reg   <= va_n2_reg;
            va_t3_reg   <= va_t2_reg;
            vb_n3_reg   <= vb_n2_reg;
            vb_t3_reg   <= vb_t2_reg;
        end
    end

    // Stage 4: tangential impulse and output register.
    logic [34:0]        fm;
    logic signed [35:0] fd;

    always_comb begin
        fm = 35'(prod3_reg >> FRAC_BITS);
        if (both3_reg) begin
            fm = fm >> 1;
        end
        fd = (vt_pos3_reg ^ tneg3_reg) ? -36'({1'b0, fm}) : 36'({1'b0, fm});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            axis4_reg <= axis3_reg;
            gr_a4_reg <= gr_a3_reg;
            gr_b4_reg <= gr_b3_reg;
            mv_a4_reg <= mv_a3_reg;
            mv_b4_reg <= mv_b3_reg;
            mova4_reg <= mova3_reg;
            movb4_reg <= movb3_reg;
            va_n4_reg <= va_n3_reg;
            vb_n4_reg <= vb_n3_reg;
            va_t4_reg <= (fric3_reg && fa3_reg) ?
                         sat32(40'(va_t3_reg) + 40'(fd)) : va_t3_reg;
            vb_t4_reg <= (fric3_reg && fb3_reg) ?
                         sat32(40'(vb_t3_reg) - 40'(fd)) : vb_t3_reg;
        end
    end

    assign m_valid       = v4_reg;
    assign m_a_move_x    = axis4_reg ? '0 : mova4_reg;
    assign m_a_move_y    = axis4_reg ? mova4_reg : '0;
    assign m_b_move_x    = axis4_reg ? '0 : movb4_reg;
    assign m_b_move_y    = axis4_reg ? movb4_reg : '0;
    assign m_new_vel_a_x = axis4_reg ? va_t4_reg : va_n4_reg;
    assign m_new_vel_a_y = axis4_reg ? va_n4_reg : va_t4_reg;
    assign m_new_vel_b_x = axis4_reg ? vb_t4_reg : vb_n4_reg;
    assign m_new_vel_b_y = axis4_reg ? vb_n4_reg : vb_t4_reg;
    assign m_a_grounded  = gr_a4_reg;
    assign m_b_grounded  = gr_b4_reg;
    assign m_a_moved     = mv_a4_reg;
    assign m_b_moved     = mv_b4_reg;

`ifndef SYNTHESIS
    a_move_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_a_move_x == 0 || m_a_move_y == 0))
        else $error("correction of A on both axes");
    a_still_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_a_moved) |-> (m_a_move_x == 0 && m_a_move_y == 0))
        else $error("A corrected without moved flag");
    grounded_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_a_grounded && m_b_grounded))
        else $error("both bodies grounded by one contact");
    stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_new_vel_a_x)))
        else $error("result transaction changed while stalled");
`endif

endmodule
